>>> design/imhck_pkg.sv
// Shared constants and types for the indexed max-heap block.
`default_nettype none
package imhck_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	// slot and id numbers run 1..DEPTH; memories index them modulo DEPTH
	localparam int SLOT_W = ADDR_W + 1;
	localparam int CNT_W  = 11;
	localparam int KEY_W  = 32;

	localparam logic signed [KEY_W-1:0] FLOOR_KEY = -KEY_W'(100000000);

	// byte address of the count register
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

	typedef logic [1:0] req_t;
	localparam req_t REQ_QUERY = 2'd0;
	localparam req_t REQ_SET   = 2'd1;
	localparam req_t REQ_CLEAR = 2'd2;
	localparam req_t REQ_RSVD  = 2'd3;

	typedef enum logic [1:0] {
		CMP_CHILD,
		CMP_DOWN,
		CMP_UP
	} cmp_op_t;

	typedef struct packed {
		logic                    key_re;
		logic [ADDR_W-1:0]       key_ra;
		logic [ADDR_W-1:0]       key_rb;
		logic                    key_we;
		logic [ADDR_W-1:0]       key_wa;
		logic signed [KEY_W-1:0] key_wd;
		logic                    own_re;
		logic [ADDR_W-1:0]       own_ra;
		logic                    own_we;
		logic [ADDR_W-1:0]       own_wa;
		logic [ADDR_W-1:0]       own_wd;
		logic                    pos_re;
		logic [ADDR_W-1:0]       pos_ra;
		logic                    pos_we;
		logic [ADDR_W-1:0]       pos_wa;
		logic [ADDR_W-1:0]       pos_wd;
	} mem_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key_a;
		logic signed [KEY_W-1:0] key_b;
		logic [ADDR_W-1:0]       own;
		logic [ADDR_W-1:0]       pos;
	} mem_rsp_t;

endpackage
`default_nettype wire

>>> design/imhck_cmp.sv
// Shared signed key comparator with operand selection.
`default_nettype none
module imhck_cmp (
	input  wire imhck_pkg::cmp_op_t                op,
	input  wire logic signed [imhck_pkg::KEY_W-1:0] key_a,
	input  wire logic signed [imhck_pkg::KEY_W-1:0] key_b,
	input  wire logic signed [imhck_pkg::KEY_W-1:0] kx,
	input  wire logic signed [imhck_pkg::KEY_W-1:0] kc,
	output logic                                    lt
);

	logic signed [imhck_pkg::KEY_W-1:0] lhs;
	logic signed [imhck_pkg::KEY_W-1:0] rhs;

	always_comb begin
		unique case (op)
			imhck_pkg::CMP_CHILD: begin
				lhs = key_a;
				rhs = key_b;
			end
			imhck_pkg::CMP_DOWN: begin
				lhs = kx;
				rhs = kc;
			end
			imhck_pkg::CMP_UP: begin
				lhs = key_a;
				rhs = kx;
			end
			default: begin
				lhs = key_a;
				rhs = key_b;
			end
		endcase
	end

	assign lt = lhs < rhs;

endmodule
`default_nettype wire

>>> design/imhck_store.sv
// Key, slot-owner and item-slot memories with registered read data.
`default_nettype none
module imhck_store (
	input  wire                       clk,
	input  wire imhck_pkg::mem_req_t  req,
	output imhck_pkg::mem_rsp_t       rsp
);

	logic signed [imhck_pkg::KEY_W-1:0] key_mem [imhck_pkg::DEPTH];
	logic [imhck_pkg::ADDR_W-1:0]       own_mem [imhck_pkg::DEPTH];
	logic [imhck_pkg::ADDR_W-1:0]       pos_mem [imhck_pkg::DEPTH];

	logic signed [imhck_pkg::KEY_W-1:0] key_a_q;
	logic signed [imhck_pkg::KEY_W-1:0] key_b_q;
	logic [imhck_pkg::ADDR_W-1:0]       own_q;
	logic [imhck_pkg::ADDR_W-1:0]       pos_q;

	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.key_wa] <= req.key_wd;
		end
		if (req.key_re) begin
			key_a_q <= key_mem[req.key_ra];
			key_b_q <= key_mem[req.key_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (req.own_we) begin
			own_mem[req.own_wa] <= req.own_wd;
		end
		if (req.own_re) begin
			own_q <= own_mem[req.own_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (req.pos_we) begin
			pos_mem[req.pos_wa] <= req.pos_wd;
		end
		if (req.pos_re) begin
			pos_q <= pos_mem[req.pos_ra];
		end
	end

	assign rsp = '{key_a: key_a_q, key_b: key_b_q, own: own_q, pos: pos_q};

endmodule
`default_nettype wire

>>> design/imhck_seq.sv
// Sequencer: clearing pass, query, and sift-down then sift-up over the heap memories.
`default_nettype none
module imhck_seq (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     cfg_wr,
	input  wire logic [imhck_pkg::CNT_W-1:0]        n,
	input  wire                                     in_valid,
	output logic                                    in_ready,
	input  wire imhck_pkg::req_t                    in_type,
	input  wire logic [imhck_pkg::CNT_W-1:0]        in_id,
	input  wire logic signed [imhck_pkg::KEY_W-1:0] in_key,
	output logic                                    out_valid,
	input  wire                                     out_ready,
	output logic signed [imhck_pkg::KEY_W-1:0]      out_key
);

	localparam int AW = imhck_pkg::ADDR_W;
	localparam int SW = imhck_pkg::SLOT_W;
	localparam int KW = imhck_pkg::KEY_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_Q_RD,
		ST_Q_OUT,
		ST_S_LOOK,
		ST_S_POS,
		ST_D_RD,
		ST_D_SEL,
		ST_D_CHK,
		ST_U_RD,
		ST_U_CMP,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic signed [KW-1:0] kx_q;
	logic signed [KW-1:0] kc_q;
	logic [AW-1:0]        who_q;
	logic [SW-1:0]        s_q;
	logic [SW-1:0]        c_q;
	logic signed [KW-1:0] top_q;
	logic                 out_valid_q;

	imhck_pkg::mem_req_t req;
	imhck_pkg::mem_rsp_t rsp;
	imhck_pkg::cmp_op_t  op;
	logic                lt;

	logic [SW:0]   c2;
	logic          down_ok;
	logic          has_right;
	logic          take_right;
	logic [SW-1:0] c_sel;
	logic [SW-1:0] p;
	logic          id_ok;

	imhck_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	imhck_cmp u_cmp (
		.op    (op),
		.key_a (rsp.key_a),
		.key_b (rsp.key_b),
		.kx    (kx_q),
		.kc    (kc_q),
		.lt    (lt)
	);

	assign c2         = {s_q, 1'b0};
	assign down_ok    = c2 <= {1'b0, n};
	assign has_right  = c2 < {1'b0, n};
	assign take_right = has_right && lt;
	// left child is even, so the right one only sets the low bit
	assign c_sel      = c2[SW-1:0] | SW'(take_right);
	assign p          = s_q >> 1;
	assign id_ok      = (in_id != '0) && (in_id <= n);

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_key   = top_q;

	always_comb begin
		unique case (state_q)
			ST_D_SEL: op = imhck_pkg::CMP_CHILD;
			ST_D_CHK: op = imhck_pkg::CMP_DOWN;
			default:  op = imhck_pkg::CMP_UP;
		endcase
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req.key_we = 1'b1;
				req.key_wa = clr_q;
				req.key_wd = '0;
				req.own_we = 1'b1;
				req.own_wa = clr_q;
				req.own_wd = clr_q;
				req.pos_we = 1'b1;
				req.pos_wa = clr_q;
				req.pos_wd = clr_q;
			end
			ST_Q_RD: begin
				req.key_re = 1'b1;
				req.key_ra = AW'(1);
				req.key_rb = AW'(1);
			end
			ST_S_LOOK: begin
				req.pos_re = 1'b1;
				req.pos_ra = who_q;
			end
			ST_D_RD: begin
				req.key_re = down_ok;
				req.key_ra = c2[AW-1:0];
				req.key_rb = c2[AW-1:0] | AW'(1);
			end
			ST_D_SEL: begin
				req.own_re = 1'b1;
				req.own_ra = c_sel[AW-1:0];
			end
			ST_D_CHK: begin
				req.key_we = lt;
				req.key_wa = s_q[AW-1:0];
				req.key_wd = kc_q;
				req.own_we = lt;
				req.own_wa = s_q[AW-1:0];
				req.own_wd = rsp.own;
				req.pos_we = lt;
				req.pos_wa = rsp.own;
				req.pos_wd = s_q[AW-1:0];
			end
			ST_U_RD: begin
				req.key_re = s_q != SW'(1);
				req.key_ra = p[AW-1:0];
				req.key_rb = p[AW-1:0];
				req.own_re = s_q != SW'(1);
				req.own_ra = p[AW-1:0];
			end
			ST_U_CMP: begin
				req.key_we = lt;
				req.key_wa = s_q[AW-1:0];
				req.key_wd = rsp.key_a;
				req.own_we = lt;
				req.own_wa = s_q[AW-1:0];
				req.own_wd = rsp.own;
				req.pos_we = lt;
				req.pos_wa = rsp.own;
				req.pos_wd = s_q[AW-1:0];
			end
			ST_FIN: begin
				req.key_we = 1'b1;
				req.key_wa = s_q[AW-1:0];
				req.key_wd = kx_q;
				req.own_we = 1'b1;
				req.own_wa = s_q[AW-1:0];
				req.own_wd = who_q;
				req.pos_we = 1'b1;
				req.pos_wa = who_q;
				req.pos_wd = s_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			kx_q        <= '0;
			kc_q        <= '0;
			who_q       <= '0;
			s_q         <= '0;
			c_q         <= '0;
			top_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				state_q <= ST_CLEAR;
				clr_q   <= '0;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (&clr_q) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_valid) begin
							who_q <= in_id[AW-1:0];
							kx_q  <= (in_type == imhck_pkg::REQ_SET) ? in_key
								: imhck_pkg::FLOOR_KEY;
							case (in_type) inside
								imhck_pkg::REQ_QUERY: state_q <= ST_Q_RD;
								imhck_pkg::REQ_SET, imhck_pkg::REQ_CLEAR: begin
									state_q <= id_ok ? ST_S_LOOK : ST_IDLE;
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					end
					ST_Q_RD: state_q <= ST_Q_OUT;
					ST_Q_OUT: begin
						if (!out_valid_q || out_ready) begin
							top_q       <= rsp.key_a;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
					ST_S_LOOK: state_q <= ST_S_POS;
					ST_S_POS: begin
						// stored slot 0 stands for slot DEPTH
						s_q     <= {~|rsp.pos, rsp.pos};
						state_q <= ST_D_RD;
					end
					ST_D_RD: state_q <= down_ok ? ST_D_SEL : ST_U_RD;
					ST_D_SEL: begin
						c_q     <= c_sel;
						kc_q    <= take_right ? rsp.key_b : rsp.key_a;
						state_q <= ST_D_CHK;
					end
					ST_D_CHK: begin
						if (lt) begin
							s_q     <= c_q;
							state_q <= ST_D_RD;
						end else begin
							state_q <= ST_U_RD;
						end
					end
					ST_U_RD: state_q <= (s_q == SW'(1)) ? ST_FIN : ST_U_CMP;
					ST_U_CMP: begin
						if (lt) begin
							s_q     <= p;
							state_q <= ST_U_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: state_q <= ST_IDLE;
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> design/indexed_max_heap_change_key.sv
// Top level: indexed max-heap with change-key, APB count register and stream ports.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: req_type; tdata: item_id, key_value
//  m_axis   | out       | tdata: top_key (query beats only)
//  apb      | in/out    | entry_count at byte address 0
//
// After reset and after every entry_count write a clearing pass rewrites all three
// memories; no beat is taken meanwhile.
// One beat at a time: a query reads the root key and returns it; a set or clear looks
// up the item's slot, walks the key down, then walks it up, and places the key. A bad
// id or reserved request is dropped. The loop is bound by the registered reads of the
// memories. A query waits in the sequencer while m_axis stalls a result already held.
`default_nettype none
module indexed_max_heap_change_key (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [47:0] s_axis_tdata,  // [10:0] item_id, [42:11] key_value, rest zero
	input  wire  [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] top_key
);

	localparam int CW = imhck_pkg::CNT_W;

	logic [CW-1:0] entry_count_q;
	logic [CW-1:0] n;
	logic          cfg_wr;
	logic          reg_hit;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			imhck_pkg::REG_ENTRY_COUNT: reg_hit = 1'b1;
			default:                    reg_hit = 1'b0;
		endcase
	end

	assign cfg_wr = psel && penable && pwrite && pready && reg_hit;
	assign prdata = reg_hit ? {{(32 - CW){1'b0}}, entry_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CW'(imhck_pkg::DEPTH);
		end else if (cfg_wr) begin
			entry_count_q <= pwdata[CW-1:0];
		end
	end

	// out-of-range counts clamp to 1..DEPTH
	always_comb begin
		if (entry_count_q == '0) begin
			n = CW'(1);
		end else if (entry_count_q > CW'(imhck_pkg::DEPTH)) begin
			n = CW'(imhck_pkg::DEPTH);
		end else begin
			n = entry_count_q;
		end
	end

	imhck_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.n         (n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_type   (s_axis_tuser),
		.in_id     (s_axis_tdata[10:0]),
		.in_key    (s_axis_tdata[42:11]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_key   (m_axis_tdata)
	);

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !s_axis_tready)
		else $error("input taken right after a count write");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == imhck_pkg::REQ_QUERY)
		|=> !s_axis_tready)
		else $error("input taken while a query is in flight");

	// the result is raised from the query's last cycle, when input is held off
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result raised outside a query");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for the indexed max-heap: stream driver, result monitor, heap predictor.
`default_nettype none
module testbench;
	import imhck_pkg::*;

	localparam logic signed [KEY_W-1:0] CLEAR_KEY = -32'sd100000000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		req_t                    kind;
		logic [CNT_W-1:0]        id;
		logic signed [KEY_W-1:0] key;
	} heap_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // [10:0] item_id, [42:11] key_value, rest zero
	logic [1:0]  s_axis_tuser = '0;  // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [31:0] top_key

	indexed_max_heap_change_key dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ---------------- heap predictor ----------------
	logic signed [KEY_W-1:0] heap_key [0:DEPTH];
	int unsigned             slot_item [0:DEPTH];
	int unsigned             item_at [0:DEPTH];
	int unsigned             live_n;

	logic signed [KEY_W-1:0] top_key_q [$];
	heap_req_t               pending_q [$];
	int                      errors = 0;

	function automatic void heap_reinit(logic [CNT_W-1:0] cnt);
		live_n = (cnt == 0) ? 1 : (cnt > DEPTH) ? DEPTH : cnt;
		for (int i = 0; i <= DEPTH; i++) begin
			heap_key[i] = '0;
			slot_item[i] = i;
			item_at[i] = i;
		end
	endfunction

	function automatic int unsigned push_down(int unsigned s, int unsigned n);
		logic signed [KEY_W-1:0] kx;
		int unsigned who, c;
		kx = heap_key[s];
		who = slot_item[s];
		c = 2 * s;
		while (c <= n) begin
			// right child only when strictly larger
			if (c < n && heap_key[c] < heap_key[c+1]) c++;
			if (!(kx < heap_key[c])) break;
			heap_key[s] = heap_key[c];
			slot_item[s] = slot_item[c];
			item_at[slot_item[s]] = s;
			s = c;
			c = 2 * s;
		end
		heap_key[s] = kx;
		slot_item[s] = who;
		item_at[who] = s;
		return s;
	endfunction

	function automatic void push_up(int unsigned s);
		logic signed [KEY_W-1:0] kx;
		int unsigned who, p;
		kx = heap_key[s];
		who = slot_item[s];
		p = s / 2;
		while (p >= 1) begin
			if (!(heap_key[p] < kx)) break;
			heap_key[s] = heap_key[p];
			slot_item[s] = slot_item[p];
			item_at[slot_item[s]] = s;
			s = p;
			p = s / 2;
		end
		heap_key[s] = kx;
		slot_item[s] = who;
		item_at[who] = s;
	endfunction

	function automatic void change_key(logic [CNT_W-1:0] id, logic signed [KEY_W-1:0] k);
		int unsigned s;
		if (id < 1 || id > live_n) return;
		s = item_at[id];
		if (s < 1 || s > live_n) return;
		heap_key[s] = k;
		s = push_down(s, live_n);
		push_up(s);
	endfunction

	function automatic void heap_request(heap_req_t r);
		case (r.kind)
			REQ_QUERY: top_key_q.push_back(heap_key[1]);
			REQ_SET:   change_key(r.id, r.key);
			REQ_CLEAR: change_key(r.id, CLEAR_KEY);
			default: ;
		endcase
	endfunction

	initial heap_reinit(CNT_W'(DEPTH));

	// ---------------- idling ----------------
	logic tx_gaps_on = 1'b1;
	logic rx_gaps_on = 1'b1;
	int   stall_ticket = 0;
	int   stall_seen = 0;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------- driver ----------------
	heap_req_t cur_req = '0;
	int        tx_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				heap_request(cur_req);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					cur_req <= pending_q[0];
					s_axis_tdata <= {5'b0, pending_q[0].key, pending_q[0].id};
					s_axis_tuser <= pending_q[0].kind;
					s_axis_tvalid <= 1'b1;
					void'(pending_q.pop_front());
					tx_gap <= (tx_gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	int rx_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (top_key_q.size() == 0) begin
					$error("top_key: beat with nothing expected, got %0d",
						$signed(m_axis_tdata));
					errors++;
				end else begin
					if (m_axis_tdata !== top_key_q[0]) begin
						$error("top_key: expected %0d, got %0d", top_key_q[0],
							$signed(m_axis_tdata));
						errors++;
					end
					void'(top_key_q.pop_front());
				end
			end
			if (stall_ticket != stall_seen) begin
				stall_seen <= stall_ticket;
				rx_hold <= 400;
				m_axis_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_gaps_on && $urandom_range(0, 99) < 25) begin
				rx_hold <= pick_gap();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------- sequencing ----------------
	function automatic heap_req_t mk(req_t kind, int id, logic [31:0] key);
		heap_req_t r;
		r.kind = kind;
		r.id = CNT_W'(id);
		r.key = key;
		return r;
	endfunction

	function automatic heap_req_t rand_req(int unsigned n);
		heap_req_t r;
		int pk, pi, pv;
		pk = $urandom_range(0, 99);
		pi = $urandom_range(0, 99);
		pv = $urandom_range(0, 99);
		r.kind = (pk < 30) ? REQ_QUERY : (pk < 82) ? REQ_SET : (pk < 97) ? REQ_CLEAR : REQ_RSVD;
		if (pi < 88)
			r.id = CNT_W'($urandom_range(1, n));
		else if (pi < 96)
			r.id = (pi[0]) ? CNT_W'(0) : CNT_W'(n + 1);
		else
			r.id = CNT_W'($urandom());
		if (pv < 40)
			r.key = $urandom_range(0, 8) - 4;  // ties are common
		else if (pv < 50)
			r.key = pv[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
		else if (pv < 55)
			r.key = CLEAR_KEY;
		else
			r.key = $urandom();
		return r;
	endfunction

	task automatic write_count(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ENTRY_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		heap_reinit(v[CNT_W-1:0]);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_q.size() != 0 || s_axis_tvalid || top_key_q.size() != 0)
			@(posedge clk);
		// sets and clears give no beat: let the last one settle
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	int counts [12] = '{2047, 0, 1, 2, 3, 5, 8, 16, 31, 100, 1024, 1025};

	initial begin
		int unsigned n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, ties, bad ids, reserved request, count at reset
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 1, 32'h7FFF_FFFF));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 1024, 32'h8000_0000));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 1024, 32'h7FFF_FFFF));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_CLEAR, 1, 0));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_CLEAR, 1024, 32'hFFFF_FFFF));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 0, 55));
		pending_q.push_back(mk(REQ_SET, 1025, 66));
		pending_q.push_back(mk(REQ_SET, 2047, 77));
		pending_q.push_back(mk(REQ_RSVD, 5, 88));
		pending_q.push_back(mk(REQ_QUERY, 2047, 32'hFFFF_FFFF));
		pending_q.push_back(mk(REQ_SET, 512, 32'h5555_5555));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 512, 32'hAAAA_AAAA));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_SET, 700, 1));
		pending_q.push_back(mk(REQ_SET, 3, 1));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		pending_q.push_back(mk(REQ_CLEAR, 700, 0));
		pending_q.push_back(mk(REQ_QUERY, 0, 0));
		drain();

		foreach (counts[p]) begin
			write_count(counts[p]);
			n = live_n;
			tx_gaps_on <= (p % 3 != 0);
			rx_gaps_on <= (p % 3 != 1);
			// long receiver hold-off while the sender keeps offering
			if (p == 3 || p == 9)
				stall_ticket <= stall_ticket + 1;
			for (int i = 0; i < 170; i++)
				pending_q.push_back(rand_req(n));
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
